/* hw/rtl/bgqm_pkg.sv */
// ----------------------------------------------------------------------------
// bgqm_pkg
// shared types and constants of the binary greedy quad merger
// ----------------------------------------------------------------------------
package bgqm_pkg;

    localparam int unsigned COORD_W = 5;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned DIR_W   = 3;
    localparam int unsigned BT_W    = 5;

    localparam logic CFG_FACE_DIRECTION = 1'b0;
    localparam logic CFG_BLOCK_TYPE     = 1'b1;

    // command broadcast to every cell
    typedef struct packed {
        logic                 load;      // take a new column
        logic                 flush;     // last column: close everything
        logic [COORD_W-1:0]   column;    // current column index
    } cell_ctrl_t;

    // quad handed down the chain
    typedef struct packed {
        logic               valid;
        logic [COORD_W-1:0] origin;
        logic [COORD_W-1:0] start;
        logic [5:0]         len;
        logic [5:0]         width;
    } quad_t;

    function automatic logic [WORD_W-1:0] pack_quad(
        input quad_t              q,
        input logic [COORD_W-1:0] slice,
        input logic [DIR_W-1:0]   dir,
        input logic [BT_W-1:0]    btype
    );
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic [4:0]         wm1;
        logic [4:0]         hm1;
        logic [4:0]         cm1;
        if (dir <= 3'd1) begin
            x = slice; y = q.start; z = q.origin;
        end else if (dir <= 3'd3) begin
            x = q.origin; y = slice; z = q.start;
        end else begin
            x = q.origin; y = q.start; z = slice;
        end
        wm1 = q.width[4:0] - 5'd1;
        hm1 = q.len[4:0] - 5'd1;
        cm1 = btype - 5'd1;
        return {cm1[3:0], dir, hm1, wm1, z, y, x};
    endfunction

endpackage

/* hw/rtl/bgqm_if.sv */
// ----------------------------------------------------------------------------
// bgqm stream interfaces
// valid/ready channels for columns, quads and configuration
// ----------------------------------------------------------------------------
interface bgqm_col_if;
    logic        valid;
    logic        ready;
    logic [4:0]  slice_index;
    logic [31:0] column_bits;
    modport source (output valid, slice_index, column_bits, input ready);
    modport sink   (input valid, slice_index, column_bits, output ready);
endinterface

interface bgqm_quad_if;
    logic        valid;
    logic        ready;
    logic [31:0] vertex_word;
    logic        last_of_item;
    modport source (output valid, vertex_word, last_of_item, input ready);
    modport sink   (input valid, vertex_word, last_of_item, output ready);
endinterface

interface bgqm_cfg_if;
    logic       valid;
    logic       ready;
    logic       index;
    logic [4:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/bgqm_cell.sv */
// ----------------------------------------------------------------------------
// bgqm_cell
// one run-start row: holds an open rectangle and shifts closed quads down
// ----------------------------------------------------------------------------
module bgqm_cell #(
    parameter int unsigned PLANE_SIZE = 32,
    parameter int unsigned POS        = 0
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  bgqm_pkg::cell_ctrl_t    ctrl,
    input  logic                    shift,
    input  logic [PLANE_SIZE-1:0]   col,
    input  logic [PLANE_SIZE-1:0]   rem,
    input  bgqm_pkg::quad_t         q_in,
    output bgqm_pkg::quad_t         q_out,
    output logic                    open,
    output logic [PLANE_SIZE-1:0]   cover_bits
);
    import bgqm_pkg::*;

    localparam int unsigned EXT_W = PLANE_SIZE + 1;

    logic               open_reg;
    logic [5:0]         len_reg;
    logic [COORD_W-1:0] org_reg;
    quad_t              slot_reg;
    quad_t              slot_next;
    logic [PLANE_SIZE-1:0] mask;
    logic               grow;
    logic               new_run;
    logic [5:0]         new_len;
    logic [PLANE_SIZE:0] ext;

    assign mask = PLANE_SIZE'(((EXT_W'(1) << len_reg) - EXT_W'(1)) << POS);
    assign grow  = open_reg && ((col & mask) == mask);
    assign cover_bits = grow ? mask : '0;

    // new run starts here if rem bit set and below is clear
    assign new_run = rem[POS] && ((POS == 0) || !rem[(POS == 0) ? 0 : POS-1]);

    // run length reaches up to the first clear bit above the start
    always_comb
    begin
        new_len = '0;
        ext = {1'b0, rem} >> POS;
        for (int k = PLANE_SIZE - 1; k >= 0; k--)
        begin
            if (!ext[k+1])
                new_len = 6'(k + 1);
        end
    end

    always_comb
    begin
        slot_next = slot_reg;
        if (ctrl.flush)
        begin
            slot_next.valid  = open_reg;
            slot_next.origin = org_reg;
            slot_next.start  = COORD_W'(POS);
            slot_next.len    = len_reg;
            slot_next.width  = 6'({1'b0, ctrl.column} - {1'b0, org_reg} + 6'd1);
        end
        else if (ctrl.load)
        begin
            slot_next.valid = 1'b0;
            if (open_reg && !grow)
            begin
                slot_next.valid  = 1'b1;
                slot_next.origin = org_reg;
                slot_next.start  = COORD_W'(POS);
                slot_next.len    = len_reg;
                slot_next.width  = {1'b0, ctrl.column} - {1'b0, org_reg};
            end
        end
        else if (shift)
        begin
            slot_next = q_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 1'b0;
            len_reg  <= '0;
            org_reg  <= '0;
            slot_reg <= '0;
        end
        else
        begin
            slot_reg <= slot_next;
            if (ctrl.flush)
                open_reg <= 1'b0;
            else if (ctrl.load)
                open_reg <= grow || new_run;
            if (ctrl.load && !grow && new_run)
            begin
                len_reg <= new_len;
                org_reg <= ctrl.column;
            end
        end
    end

    assign q_out = slot_reg;
    assign open  = open_reg;
endmodule

/* hw/rtl/binary_greedy_quad_merger_unit.sv */
// ----------------------------------------------------------------------------
// binary_greedy_quad_merger_unit
// greedy rectangle merger over one face plane, one column per beat
// ----------------------------------------------------------------------------
// channel  dir  beat contents
// col      in   slice_index, column_bits
// quad     out  vertex_word, last_of_item
// cfg      in   index (0 face_direction, 1 block_type), data
//
// a column is taken when the chain holds no quads and no flush is pending; a
// quad closed at run start r reaches cell 0 after r shifts, and the next
// column waits until every closed quad has left the chain
// the last column of a plane adds one flush pass once its closed quads have
// drained, then the flushed quads drain through the chain the same way
// a held output beat with quad.ready low stalls the chain unless cell 0 is empty
// reset clears the column counter, the flush flag, every open flag and the chain
// ----------------------------------------------------------------------------
module binary_greedy_quad_merger_unit #(
    parameter int unsigned PLANE_SIZE = 32
) (
    input logic          clk,
    input logic          rst_n,
    bgqm_col_if.sink     col,
    bgqm_quad_if.source  quad,
    bgqm_cfg_if.sink     cfg
);
    import bgqm_pkg::*;

    logic [DIR_W-1:0]   dir_reg;
    logic [BT_W-1:0]    bt_reg;
    logic [COORD_W-1:0] count_reg;
    logic [COORD_W-1:0] slice_reg;
    logic               flush_pend_reg;
    logic               out_valid_reg;
    logic [WORD_W-1:0]  out_word_reg;
    logic               out_last_reg;

    cell_ctrl_t            ctrl;
    logic [PLANE_SIZE-1:0] colm;
    logic [PLANE_SIZE-1:0] rem;
    logic [PLANE_SIZE-1:0] cover_bits [PLANE_SIZE];
    logic [PLANE_SIZE-1:0] opens;
    quad_t                 chain [PLANE_SIZE+1];
    logic [PLANE_SIZE-1:0] pend;
    logic                  busy;
    logic                  last_col;
    logic                  out_free;
    logic                  shift;
    logic                  more;

    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg <= '0;
            bt_reg  <= 5'd1;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_FACE_DIRECTION: dir_reg <= cfg.data[DIR_W-1:0];
                CFG_BLOCK_TYPE:     bt_reg  <= cfg.data;
                default:            ;
            endcase
        end
    end

    assign colm = col.column_bits[PLANE_SIZE-1:0];

    // bits covered by growing rectangles leave the column
    always_comb
    begin
        rem = colm;
        for (int i = 0; i < PLANE_SIZE; i++)
            rem = rem & ~cover_bits[i];
    end

    // chain bottom is cell 0; quads move toward lower index, out at cell 0
    genvar g;
    generate
        for (g = 0; g < PLANE_SIZE; g++)
        begin : g_cell
            assign pend[g] = chain[g].valid;
            bgqm_cell #(.PLANE_SIZE(PLANE_SIZE), .POS(g)) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .shift      (shift),
                .col        (colm),
                .rem        (rem),
                .q_in       (chain[g+1]),
                .q_out      (chain[g]),
                .open       (opens[g]),
                .cover_bits (cover_bits[g])
            );
        end
    endgenerate
    assign chain[PLANE_SIZE] = '0;

    // last column: closed quads drain first, then one flush pass loads the
    // still open rectangles into the chain
    assign busy      = |pend;
    assign last_col  = (count_reg >= COORD_W'(PLANE_SIZE-1));
    assign col.ready = !busy && !flush_pend_reg;
    assign ctrl.load   = col.valid && !busy && !flush_pend_reg;
    assign ctrl.flush  = flush_pend_reg && !busy;
    assign ctrl.column = count_reg;

    assign out_free = !out_valid_reg || quad.ready;
    // shift while a quad sits somewhere and cell 0 is empty or the output is free; empty bottom just compacts
    assign shift = busy && (out_free || !pend[0]);
    assign more  = |pend[PLANE_SIZE-1:1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            flush_pend_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (ctrl.load)
            begin
                if (last_col)
                    flush_pend_reg <= 1'b1;
                else
                    count_reg <= count_reg + COORD_W'(1);
            end
            if (ctrl.flush)
            begin
                flush_pend_reg <= 1'b0;
                count_reg      <= '0;
            end
            if (out_free)
                out_valid_reg <= shift && pend[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
            slice_reg <= col.slice_index;
        if (out_free && shift && pend[0])
        begin
            out_word_reg <= pack_quad(chain[0], slice_reg, dir_reg, bt_reg);
            // a pending flush with open rectangles still follows this beat
            out_last_reg <= !more && !(flush_pend_reg && |opens);
        end
    end

    assign quad.valid        = out_valid_reg;
    assign quad.vertex_word  = out_word_reg;
    assign quad.last_of_item = out_last_reg;
endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the quad merger against a cycle-free plane predictor: directed
// columns first, then random planes under random source and sink stalls
// ----------------------------------------------------------------------------
module testbench;
    import bgqm_pkg::*;

    localparam int PLANE      = 32;
    localparam int LIMIT      = 3000000;
    localparam int SETTLE     = 80;
    localparam int NUM_ITEMS  = 300;

    // one expected quad beat
    typedef struct packed {
        logic [31:0] word;
        logic        last;
    } quad_beat_t;

    // directed column row; check_word set means the first quad is typed in
    typedef struct packed {
        logic [4:0]  slice;
        logic [31:0] bits;
        logic        check_word;
        logic [31:0] word;
    } column_row_t;

    logic clk;
    logic rst_n;

    bgqm_col_if  col ();
    bgqm_quad_if quad ();
    bgqm_cfg_if  cfg ();

    binary_greedy_quad_merger_unit #(.PLANE_SIZE(PLANE)) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .col   (col),
        .quad  (quad),
        .cfg   (cfg)
    );

    // predictor copy of the block state
    logic [2:0]  face_dir;
    logic [4:0]  btype;
    logic [4:0]  col_count;
    logic [31:0] open_starts;
    logic [5:0]  open_len [PLANE];
    logic [4:0]  open_origin [PLANE];

    quad_beat_t  quad_q [$];
    quad_beat_t  new_quads [$];
    int          mismatches;
    int          cycles;
    bit          burst_mode;

    column_row_t rows [12];

    // clock: 8 ns period
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // run watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("binary_greedy_quad_merger_unit test failed");
            $finish;
        end
    end

    // pack one quad word from its geometry
    function automatic logic [31:0] quad_word(input logic [4:0] origin, input logic [4:0] start,
                                              input logic [5:0] len, input logic [5:0] width,
                                              input logic [4:0] slice);
        logic [4:0] x;
        logic [4:0] y;
        logic [4:0] z;
        logic [4:0] wm1;
        logic [4:0] hm1;
        logic [4:0] cm1;
        if (face_dir <= 3'd1)
        begin
            x = slice; y = start; z = origin;
        end
        else if (face_dir <= 3'd3)
        begin
            x = origin; y = slice; z = start;
        end
        else
        begin
            x = origin; y = start; z = slice;
        end
        wm1 = width[4:0] - 5'd1;
        hm1 = len[4:0] - 5'd1;
        cm1 = btype - 5'd1;
        return {cm1[3:0], face_dir, hm1, wm1, z, y, x};
    endfunction

    // merge one column into the open rectangles, quads land in new_quads
    task automatic merge_column(input logic [4:0] slice, input logic [31:0] bits);
        logic [31:0] remain;
        logic [31:0] run;
        int          y;
        int          start;
        remain = bits;
        new_quads.delete();
        // grow or close open rectangles, ascending run start
        for (int s = 0; s < PLANE; s++)
        begin
            if (open_starts[s])
            begin
                run = 32'(((64'd1 << open_len[s]) - 64'd1) << s);
                if ((bits & run) == run)
                    remain &= ~run;
                else
                begin
                    new_quads.push_back('{quad_word(open_origin[s], 5'(s), open_len[s],
                                          6'(col_count - open_origin[s]), slice), 1'b0});
                    open_starts[s] = 1'b0;
                end
            end
        end
        // new runs from what is left
        y = 0;
        while (y < PLANE)
        begin
            if (remain[y])
            begin
                start = y;
                while (y < PLANE && remain[y])
                    y++;
                open_starts[start] = 1'b1;
                open_len[start]    = 6'(y - start);
                open_origin[start] = col_count;
            end
            else
                y++;
        end
        // last column flushes the plane
        if (col_count == 5'(PLANE - 1))
        begin
            for (int s = 0; s < PLANE; s++)
                if (open_starts[s])
                    new_quads.push_back('{quad_word(open_origin[s], 5'(s), open_len[s],
                                          6'(col_count - open_origin[s] + 1), slice), 1'b0});
            open_starts = '0;
            col_count   = '0;
        end
        else
            col_count = col_count + 5'd1;
        if (new_quads.size() > 0)
            new_quads[new_quads.size() - 1].last = 1'b1;
    endtask

    // gap before a beat: zero in burst mode, else drawn at random
    function automatic int draw_gap();
        if (burst_mode)
            return 0;
        return $urandom_range(0, 16);
    endfunction

    // send one column beat; valid stays high into the next beat if no gap
    task automatic send_column(input logic [4:0] slice, input logic [31:0] bits,
                               input logic check_word, input logic [31:0] word);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            col.valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        col.valid       = 1'b1;
        col.slice_index = slice;
        col.column_bits = bits;
        do @(posedge clk); while (!col.ready);
        merge_column(slice, bits);
        if (check_word && new_quads.size() > 0)
            new_quads[0].word = word;
        foreach (new_quads[k])
            quad_q.push_back(new_quads[k]);
    endtask

    // write one register while the block is idle
    task automatic write_reg(input logic index, input logic [4:0] data);
        @(negedge clk);
        col.valid  = 1'b0;
        wait (quad_q.size() == 0);
        repeat (SETTLE) @(posedge clk);
        @(negedge clk);
        cfg.valid  = 1'b1;
        cfg.index  = index;
        cfg.data   = data;
        do @(posedge clk); while (!cfg.ready);
        if (index == CFG_FACE_DIRECTION)
            face_dir = data[2:0];
        else
            btype = data;
        @(negedge clk);
        cfg.valid = 1'b0;
    endtask

    // next column of a random plane: mostly coherent shapes, some noise; mode 0 gives fully random columns
    function automatic logic [31:0] next_column(input logic [31:0] prev, input int mode);
        logic [31:0] c;
        int lo;
        int hi;
        c = prev;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: c = prev;
            4, 5:
            begin
                lo = $urandom_range(0, 31);
                hi = $urandom_range(lo, 31);
                c  = prev ^ 32'(((64'd1 << (hi - lo + 1)) - 64'd1) << lo);
            end
            6:       c = prev & ~(32'd1 << $urandom_range(0, 31));
            7:       c = 32'hFFFF_FFFF;
            8:       c = '0;
            default: c = $urandom();
        endcase
        if (mode == 0)
            c = $urandom();
        return c;
    endfunction

    // quad sink: random stall drawn per beat
    initial
    begin
        int stall;
        quad.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            stall = draw_gap();
            if (stall > 0)
            begin
                @(negedge clk);
                quad.ready = 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            quad.ready = 1'b1;
            do @(posedge clk); while (!quad.valid);
        end
    end

    // quad checker
    always @(posedge clk)
    begin
        quad_beat_t exp_beat;
        if (rst_n && quad.valid && quad.ready)
        begin
            if (quad_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected quad %h last %b", quad.vertex_word, quad.last_of_item);
            end
            else
            begin
                exp_beat = quad_q.pop_front();
                if (quad.vertex_word !== exp_beat.word || quad.last_of_item !== exp_beat.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("quad mismatch: expected %h last %b, got %h last %b",
                                 exp_beat.word, exp_beat.last,
                                 quad.vertex_word, quad.last_of_item);
                end
            end
        end
    end

    // burst toggling so some stretches run with no idling
    always @(posedge clk)
        if ($urandom_range(0, 99) == 0)
            burst_mode <= ~burst_mode;

    initial
    begin
        logic [31:0] prev;
        int          sent;
        int          mode;
        mismatches  = 0;
        cycles      = 0;
        burst_mode  = 1'b0;
        face_dir    = 3'd0;
        btype       = 5'd1;
        col_count   = '0;
        open_starts = '0;
        col.valid       = 1'b0;
        col.slice_index = '0;
        col.column_bits = '0;
        cfg.valid = 1'b0;
        cfg.index = CFG_FACE_DIRECTION;
        cfg.data  = '0;
        rst_n     = 1'b0;

        // directed plane start; full column closes to one tall quad after reset
        rows[0]  = '{5'd31, 32'hFFFF_FFFF, 1'b0, 32'h0};
        rows[1]  = '{5'd31, 32'h0000_0000, 1'b1, 32'h01F0_001F};
        rows[2]  = '{5'd0,  32'h0000_0001, 1'b0, 32'h0};
        rows[3]  = '{5'd5,  32'h8000_0000, 1'b0, 32'h0};
        rows[4]  = '{5'd7,  32'h8000_0001, 1'b0, 32'h0};
        rows[5]  = '{5'd9,  32'hFFFF_FFFF, 1'b0, 32'h0};
        rows[6]  = '{5'd3,  32'h0000_FF00, 1'b0, 32'h0};
        rows[7]  = '{5'd0,  32'h5555_AAAA, 1'b0, 32'h0};
        rows[8]  = '{5'd31, 32'hAAAA_5555, 1'b0, 32'h0};
        rows[9]  = '{5'd16, 32'hFFFF_FFFF, 1'b0, 32'h0};
        rows[10] = '{5'd1,  32'h7FFF_FFFE, 1'b0, 32'h0};
        rows[11] = '{5'd2,  32'h7FFF_FFFE, 1'b0, 32'h0};

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (rows[r])
            send_column(rows[r].slice, rows[r].bits, rows[r].check_word, rows[r].word);

        // mid-plane register change
        write_reg(CFG_FACE_DIRECTION, 5'd2);
        write_reg(CFG_BLOCK_TYPE, 5'd16);

        // random planes, registers swept at plane boundaries
        sent = 0;
        prev = 32'hFFFF_FFFF;
        mode = 1;
        while (sent < NUM_ITEMS || col_count != 0)
        begin
            if (col_count == 0)
            begin
                case ($urandom_range(0, 3))
                    0: write_reg(CFG_FACE_DIRECTION, 5'($urandom_range(0, 7)));
                    1: write_reg(CFG_BLOCK_TYPE, 5'($urandom_range(0, 31)));
                    2:
                    begin
                        write_reg(CFG_FACE_DIRECTION, {2'b00, 3'($urandom_range(0, 1) * 7)});
                        write_reg(CFG_BLOCK_TYPE, ($urandom_range(0, 1) == 0) ? 5'd1 : 5'd31);
                    end
                    default: ;
                endcase
                mode = ($urandom_range(0, 4) == 0) ? 0 : 1;
                prev = $urandom();
            end
            prev = next_column(prev, mode);
            send_column(5'($urandom_range(0, 31)), prev, 1'b0, 32'h0);
            sent++;
        end
        @(negedge clk);
        col.valid = 1'b0;

        wait (quad_q.size() == 0);
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0 && quad_q.size() == 0)
            $display("binary_greedy_quad_merger_unit test passed");
        else
            $display("binary_greedy_quad_merger_unit test failed");
        $finish;
    end

endmodule
